[rtl/macsd_pkg.sv]
package macsd_pkg;

   localparam int ADDR_W      = 48;
   localparam int MAKER_W     = 16;
   localparam int FRAME_W     = 12;
   localparam int COUNT_W     = 16;
   localparam int ENTRY_IDX_W = 15;
   localparam int PLEN_W      = 3;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // wide enough for any table index and for the largest table depth itself
   localparam int IDX_EXT_W   = 17;

   localparam int CACHE_DEPTH_DEF = 64;
   localparam int TABLE_DEPTH_DEF = 32768;

   localparam logic [FRAME_W-1:0] MIN_FRAME = 12'd24;

   localparam logic OP_OBSERVE     = 1'b0;
   localparam logic OP_TABLE_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TABLE_COUNT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_SHOW_UNKNOWN = 1'b1;

   typedef struct packed {
      logic [ADDR_W-1:0]  prefix;
      logic [PLEN_W-1:0]  plen;
      logic [MAKER_W-1:0] maker;
   } tbl_word_type;

   // right-align the leading plen bytes of an address; 0 acts as 1, 7 as 6
   function automatic logic [ADDR_W-1:0] prefix_key(input logic [ADDR_W-1:0] addr,
                                                    input logic [PLEN_W-1:0] plen);
      logic [ADDR_W-1:0] key;
      unique case (plen)
         3'd0, 3'd1: key = addr >> 40;
         3'd2:       key = addr >> 32;
         3'd3:       key = addr >> 24;
         3'd4:       key = addr >> 16;
         3'd5:       key = addr >> 8;
         3'd6, 3'd7: key = addr;
      endcase
      return key;
   endfunction

endpackage

[rtl/mac_sighting_dedup_and_vendor_lookup_core.sv]
// Address sighting filter with maker lookup.
// Command channel: start with the req_ fields is taken when busy is low.
// req_op table write stores one prefix table entry in that cycle and leaves
// busy low. req_op observe with a frame of at least 24 bytes raises busy and
// checks first, then second address against the seen cache; each new address
// is entered in the cache and binary-searched in the sorted prefix table.
// Result words leave on the rsp_ ports, each marked by rsp_valid for one
// cycle; the receiver cannot stall them, and rsp_last marks the final word.
// Work per observed frame: per address, a cache scan over the cached entries
// (one registered cache read and one compare per cycle), then a binary search
// of the prefix table in at most log2(table_count) + 1 steps, each
// step one registered table read and one pass through the shared 48-bit
// comparator; then up to two result words are output.
// Configuration (csr_) is always ready and must be written while busy is low.
// Synchronous reset empties the cache and clears both configuration
// registers; prefix table contents are left as they are.
module mac_sighting_dedup_and_vendor_lookup_core #(
   parameter int CACHE_DEPTH = macsd_pkg::CACHE_DEPTH_DEF,
   parameter int TABLE_DEPTH = macsd_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [macsd_pkg::FRAME_W-1:0]       req_frame_length,
   input  logic [macsd_pkg::ADDR_W-1:0]        req_first_address,
   input  logic [macsd_pkg::ADDR_W-1:0]        req_second_address,
   input  logic [macsd_pkg::ENTRY_IDX_W-1:0]   req_entry_index,
   input  logic [macsd_pkg::ADDR_W-1:0]        req_entry_prefix,
   input  logic [macsd_pkg::PLEN_W-1:0]        req_entry_prefix_bytes,
   input  logic [macsd_pkg::MAKER_W-1:0]       req_entry_maker,
   output logic                                rsp_valid,
   output logic [macsd_pkg::ADDR_W-1:0]        rsp_seen_address,
   output logic                                rsp_which_address,
   output logic [macsd_pkg::MAKER_W-1:0]       rsp_maker_id,
   output logic                                rsp_cache_cleared,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [macsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [macsd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import macsd_pkg::*;

   localparam int CIDX_W = $clog2(CACHE_DEPTH);
   localparam int FILL_W = $clog2(CACHE_DEPTH + 1);
   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int TC_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_PROBE = 5'b00100,
      ST_CMP   = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [COUNT_W-1:0]   table_count_ff, table_count_in;
   logic                 show_unknown_ff, show_unknown_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [FILL_W-1:0]    cnt_ff, cnt_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic                 sel_ff, sel_in;
   logic                 clr_ff, clr_in;
   logic [ADDR_W-1:0]    a0_ff, a0_in, a1_ff, a1_in;
   logic [CNT_W-1:0]     lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_W-1:0]     med_ff, med_in;
   logic [1:0]           res_vld_ff, res_vld_in;
   logic [ADDR_W-1:0]    res_addr_ff [2];
   logic [ADDR_W-1:0]    res_addr_in [2];
   logic [MAKER_W-1:0]   res_maker_ff [2];
   logic [MAKER_W-1:0]   res_maker_in [2];
   logic [1:0]           res_clr_ff, res_clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic                 rsp_which_ff, rsp_which_in;
   logic [MAKER_W-1:0]   rsp_maker_ff, rsp_maker_in;
   logic                 rsp_clr_ff, rsp_clr_in;
   logic                 rsp_last_ff, rsp_last_in;

   // memories
   logic [ADDR_W-1:0]    seen_mem [CACHE_DEPTH];
   logic [ADDR_W-1:0]    seen_rd_ff;
   tbl_word_type         tbl_mem [TABLE_DEPTH];
   tbl_word_type         tbl_rd_ff;

   logic                 seen_we, seen_re;
   logic [CIDX_W-1:0]    seen_widx;
   logic                 tbl_we, tbl_re;
   logic [IDX_EXT_W-1:0] entry_idx_ext;
   tbl_word_type         tbl_wdata;

   logic [ADDR_W-1:0]    cur_addr;
   logic [ADDR_W-1:0]    cmp_a, cmp_b;
   logic                 cmp_eq, cmp_gt;
   logic [CNT_W:0]       med_sum;
   logic [TC_W-1:0]      tc_ext;
   logic [CNT_W-1:0]     hi_init;
   logic                 fin, next_addr;
   logic [MAKER_W-1:0]   fin_maker;

   assign cur_addr      = sel_ff ? a1_ff : a0_ff;
   assign entry_idx_ext = IDX_EXT_W'(req_entry_index);
   assign tbl_wdata     = '{prefix: req_entry_prefix, plen: req_entry_prefix_bytes,
                            maker: req_entry_maker};
   assign med_sum       = (CNT_W + 1)'(lo_ff) + (CNT_W + 1)'(hi_ff);
   assign tc_ext        = TC_W'(table_count_ff);
   assign hi_init       = (tc_ext > TC_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                        : CNT_W'(tc_ext);

   // shared comparator: cache entry against address while scanning,
   // stored prefix against the address key while searching
   always_comb begin
      if (state_ff == ST_CMP) begin
         cmp_a = prefix_key(cur_addr, tbl_rd_ff.plen);
         cmp_b = tbl_rd_ff.prefix;
      end else begin
         cmp_a = cur_addr;
         cmp_b = seen_rd_ff;
      end
   end
   assign cmp_eq = (cmp_a == cmp_b);
   assign cmp_gt = (cmp_a > cmp_b);

   always_comb begin
      state_in        = state_ff;
      table_count_in  = table_count_ff;
      show_unknown_in = show_unknown_ff;
      fill_in         = fill_ff;
      cnt_in          = cnt_ff;
      rd_vld_in       = 1'b0;
      sel_in          = sel_ff;
      clr_in          = clr_ff;
      a0_in           = a0_ff;
      a1_in           = a1_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      med_in          = med_ff;
      res_vld_in      = res_vld_ff;
      res_addr_in     = res_addr_ff;
      res_maker_in    = res_maker_ff;
      res_clr_in      = res_clr_ff;
      rsp_valid_in    = 1'b0;
      rsp_addr_in     = rsp_addr_ff;
      rsp_which_in    = rsp_which_ff;
      rsp_maker_in    = rsp_maker_ff;
      rsp_clr_in      = rsp_clr_ff;
      rsp_last_in     = rsp_last_ff;
      seen_we         = 1'b0;
      seen_re         = 1'b0;
      seen_widx       = fill_ff[CIDX_W-1:0];
      tbl_we          = 1'b0;
      tbl_re          = 1'b0;
      fin             = 1'b0;
      fin_maker       = '0;
      next_addr       = 1'b0;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_TABLE_COUNT:  table_count_in  = csr_data[COUNT_W-1:0];
            REG_SHOW_UNKNOWN: show_unknown_in = csr_data[0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == OP_TABLE_WRITE) begin
                  // drop writes beyond the table
                  tbl_we = (entry_idx_ext < IDX_EXT_W'(TABLE_DEPTH));
               end else if (req_frame_length >= MIN_FRAME) begin
                  a0_in      = req_first_address;
                  a1_in      = req_second_address;
                  sel_in     = 1'b0;
                  cnt_in     = '0;
                  res_vld_in = '0;
                  state_in   = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // address zero always counts as seen
            if ((cur_addr == '0) || (rd_vld_ff && cmp_eq)) begin
               next_addr = 1'b1;
            end else if (cnt_ff < fill_ff) begin
               seen_re   = 1'b1;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               seen_we = 1'b1;
               if (fill_ff == FILL_W'(CACHE_DEPTH)) begin
                  seen_widx = '0;
                  fill_in   = FILL_W'(1);
                  clr_in    = 1'b1;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  clr_in  = 1'b0;
               end
               lo_in    = '0;
               hi_in    = hi_init;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               tbl_re   = 1'b1;
               med_in   = med_sum[IDX_W:1];
               state_in = ST_CMP;
            end else begin
               fin = 1'b1;
            end
         end
         ST_CMP: begin
            if (cmp_eq) begin
               fin       = 1'b1;
               fin_maker = tbl_rd_ff.maker;
            end else begin
               if (cmp_gt) begin
                  lo_in = CNT_W'(med_ff) + 1'b1;
               end else begin
                  hi_in = CNT_W'(med_ff);
               end
               state_in = ST_PROBE;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            if (res_vld_ff[0]) begin
               rsp_addr_in   = res_addr_ff[0];
               rsp_which_in  = 1'b0;
               rsp_maker_in  = res_maker_ff[0];
               rsp_clr_in    = res_clr_ff[0];
               rsp_last_in   = !res_vld_ff[1];
               res_vld_in[0] = 1'b0;
               if (!res_vld_ff[1]) begin
                  state_in = ST_IDLE;
               end
            end else begin
               rsp_addr_in   = res_addr_ff[1];
               rsp_which_in  = 1'b1;
               rsp_maker_in  = res_maker_ff[1];
               rsp_clr_in    = res_clr_ff[1];
               rsp_last_in   = 1'b1;
               res_vld_in[1] = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (fin) begin
         if ((fin_maker != '0) || show_unknown_ff) begin
            res_vld_in[sel_ff]   = 1'b1;
            res_addr_in[sel_ff]  = cur_addr;
            res_maker_in[sel_ff] = fin_maker;
            res_clr_in[sel_ff]   = clr_ff;
         end
         next_addr = 1'b1;
      end

      if (next_addr) begin
         if (!sel_ff) begin
            sel_in   = 1'b1;
            cnt_in   = '0;
            state_in = ST_SCAN;
         end else if (res_vld_in != '0) begin
            state_in = ST_EMIT;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         table_count_ff  <= '0;
         show_unknown_ff <= 1'b0;
         fill_ff         <= '0;
         rd_vld_ff       <= 1'b0;
         res_vld_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         table_count_ff  <= table_count_in;
         show_unknown_ff <= show_unknown_in;
         fill_ff         <= fill_in;
         rd_vld_ff       <= rd_vld_in;
         res_vld_ff      <= res_vld_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      sel_ff       <= sel_in;
      clr_ff       <= clr_in;
      a0_ff        <= a0_in;
      a1_ff        <= a1_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      med_ff       <= med_in;
      res_addr_ff  <= res_addr_in;
      res_maker_ff <= res_maker_in;
      res_clr_ff   <= res_clr_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_which_ff <= rsp_which_in;
      rsp_maker_ff <= rsp_maker_in;
      rsp_clr_ff   <= rsp_clr_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_widx] <= cur_addr;
      end
      if (seen_re) begin
         seen_rd_ff <= seen_mem[cnt_ff[CIDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[entry_idx_ext[IDX_W-1:0]] <= tbl_wdata;
      end
      if (tbl_re) begin
         tbl_rd_ff <= tbl_mem[med_in];
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_seen_address  = rsp_addr_ff;
   assign rsp_which_address = rsp_which_ff;
   assign rsp_maker_id      = rsp_maker_ff;
   assign rsp_cache_cleared = rsp_clr_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(CACHE_DEPTH))
      else $error("seen cache fill beyond depth");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (lo_ff <= hi_ff))
      else $error("search range inverted");

   a_word_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without work in progress");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_which_address && !rsp_last) |=> (rsp_valid && rsp_which_address))
      else $error("second result word missing");

   a_observe_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_OBSERVE) && (req_frame_length >= MIN_FRAME))
      |=> busy)
      else $error("accepted frame did not raise busy");
`endif

endmodule
